// ===== hw/rtl/int_to_base_ascii_macros.svh =====
// assertion macros used by the checker file of int_to_base_ascii
`ifndef INT_TO_BASE_ASCII_MACROS_SVH
`define INT_TO_BASE_ASCII_MACROS_SVH

// same-cycle implication, disabled during reset
`define ITBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ITBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/itba_pkg.sv =====
// shared types, constants and the digit-to-character map of int_to_base_ascii
package itba_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int BASE_WIDTH  = 6;
  localparam int CHAR_WIDTH  = 7;
  localparam int DIGIT_WIDTH = 6;
  // a base-2 rendering needs one digit per value bit
  localparam int DIGIT_DEPTH = VALUE_WIDTH;
  localparam int PTR_WIDTH   = $clog2(DIGIT_DEPTH);

  localparam logic [BASE_WIDTH-1:0]  BASE_MIN       = 6'd2;
  localparam logic [BASE_WIDTH-1:0]  BASE_MAX       = 6'd36;
  localparam logic [DIGIT_WIDTH-1:0] DECIMAL_LIMIT  = 6'd10;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO      = 7'h30;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_NINE      = 7'h39;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_LETTER_A  = 7'h41;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_LETTER_Z  = 7'h5A;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS     = 7'h2D;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [BASE_WIDTH-1:0]         base;
  } req_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  last;
  } rsp_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_LETTER_A + CHAR_WIDTH'(d - DECIMAL_LIMIT);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/int_to_base_ascii.sv =====
// top level: signed integer to ascii text in a radix from 2 to 36
// Converts one request (signed value, base) into its ascii text, one character per
// response, most significant character first, with last set on the final one. A
// negative value gets a leading '-' and its magnitude is taken unsigned, so the most
// negative value converts correctly; zero gives "0". A request whose base is outside
// 2..36 is taken and dropped with no response. The conversion is a bit-serial
// restoring divide by the base: one quotient bit per cycle through a 6-bit remainder,
// repeated on the quotient just formed for each further digit. Digits come out least
// significant first and go into a small digit stack, which is then read back in
// reverse, each character taking one registered memory read and one output load.
// One request is in flight at a time; req_stall is low only while the block is idle,
// and the final character may still sit in the output register waiting on rsp_stall
// when the next request is taken.
module int_to_base_ascii
  import itba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_SIGN  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_PUT   = 5'b10000
  } state_t;

  state_t state;

  // conversion registers
  logic                   neg;
  logic [VALUE_WIDTH-1:0] quot;
  logic [DIGIT_WIDTH-1:0] rem;
  logic                   qnz;
  logic [PTR_WIDTH-1:0]   bitcnt;
  logic [PTR_WIDTH-1:0]   ndig;
  logic [PTR_WIDTH-1:0]   rd_ptr;
  logic [BASE_WIDTH-1:0]  base_q;

  // digit stack, least significant digit at index 0
  logic [DIGIT_WIDTH-1:0] mem [DIGIT_DEPTH];
  logic [DIGIT_WIDTH-1:0] rd_data;

  logic                   base_ok;
  logic [VALUE_WIDTH-1:0] value_bits;
  logic [VALUE_WIDTH-1:0] mag;
  logic [DIGIT_WIDTH:0]   trial;
  logic                   ge;
  logic [DIGIT_WIDTH-1:0] rem_next;
  logic                   div_done;
  logic                   rsp_free;
  logic                   rsp_load;

  assign req_stall = (state != ST_IDLE);

  // request decode: range check and two's complement magnitude
  assign base_ok    = (req.base >= BASE_MIN) && (req.base <= BASE_MAX);
  assign value_bits = req.value;
  assign mag        = value_bits[VALUE_WIDTH-1] ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;

  // one restoring-divide step: bring in the next dividend bit, subtract base if it fits
  assign trial    = {rem, quot[VALUE_WIDTH-1]};
  assign ge       = (trial >= {1'b0, base_q});
  assign rem_next = ge ? DIGIT_WIDTH'(trial - {1'b0, base_q}) : trial[DIGIT_WIDTH-1:0];
  assign div_done = (bitcnt == PTR_WIDTH'(VALUE_WIDTH - 1));

  // output register frees when empty or being taken this cycle
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign rsp_load = rsp_free && ((state == ST_SIGN) || (state == ST_PUT));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          // bad base: request is consumed with no response
          if (req_valid && base_ok) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // quotient zero after this digit ends the divide phase
          if (div_done && !(qnz || ge)) begin
            state <= neg ? ST_SIGN : ST_FETCH;
          end
        end
        ST_SIGN: begin
          if (rsp_free) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (rsp_free) begin
            state <= (rd_ptr == '0) ? ST_IDLE : ST_FETCH;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        neg    <= value_bits[VALUE_WIDTH-1];
        quot   <= mag;
        rem    <= '0;
        qnz    <= 1'b0;
        bitcnt <= '0;
        ndig   <= '0;
        base_q <= req.base;
      end
      ST_DIV: begin
        // quotient bits shift in from the right as dividend bits leave on the left
        quot   <= {quot[VALUE_WIDTH-2:0], ge};
        rem    <= rem_next;
        qnz    <= qnz || ge;
        bitcnt <= bitcnt + PTR_WIDTH'(1);
        if (div_done) begin
          // start the next digit on the quotient just formed
          rem    <= '0;
          qnz    <= 1'b0;
          bitcnt <= '0;
          if (qnz || ge) begin
            ndig <= ndig + PTR_WIDTH'(1);
          end else begin
            rd_ptr <= ndig;
          end
        end
      end
      ST_PUT: begin
        if (rsp_free && (rd_ptr != '0)) begin
          rd_ptr <= rd_ptr - PTR_WIDTH'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // digit stack write and registered read
  always_ff @(posedge clk) begin
    if ((state == ST_DIV) && div_done) begin
      mem[ndig] <= rem_next;
    end
    rd_data <= mem[rd_ptr];
  end

  // response payload
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (state == ST_SIGN) begin
        rsp.character <= CHAR_MINUS;
        rsp.last      <= 1'b0;
      end else begin
        rsp.character <= digit_char(rd_data);
        rsp.last      <= (rd_ptr == '0);
      end
    end
  end

endmodule

// ===== hw/rtl/itba_checker.sv =====
// port-level checker for int_to_base_ascii and its bind
`include "int_to_base_ascii_macros.svh"

module itba_checker
  import itba_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled response holds
  `ITBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // only '-', digits and upper-case letters appear
  `ITBA_ASSERT_SAME(a_char_legal, rsp_valid, (rsp.character == CHAR_MINUS) || ((rsp.character >= CHAR_ZERO) && (rsp.character <= CHAR_NINE)) || ((rsp.character >= CHAR_LETTER_A) && (rsp.character <= CHAR_LETTER_Z)), "illegal character")

  // the sign is never the final character
  `ITBA_ASSERT_SAME(a_sign_not_last, rsp_valid && (rsp.character == CHAR_MINUS), !rsp.last, "sign flagged last")

  // a request with a usable base keeps the block busy the next cycle
  `ITBA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall && (req.base >= BASE_MIN) && (req.base <= BASE_MAX), req_stall, "not busy after request")

endmodule

bind int_to_base_ascii itba_checker u_itba_checker (.*);
